// ===== rtl/stbc_pkg.sv =====
// Shared types, constants and helper functions for the spectrum-to-chord block.
`default_nettype none

package stbc_pkg;

    // Field widths
    localparam int MAG_W    = 24;
    localparam int IDX_W    = 11;
    localparam int THR_W    = 16;
    localparam int STEP_W   = 16;
    localparam int PROD_W   = IDX_W + STEP_W;
    localparam int NORM_W   = 32;
    localparam int SHIFT_W  = $clog2(NORM_W);
    localparam int PC_N     = 12;
    localparam int PC_W     = 4;
    localparam int KIND_W   = 3;
    localparam int CNT_W    = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Queue between the front and back parts
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BIN = 2'd2;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd40;
    localparam logic [STEP_W-1:0] BIN_STEP_RST  = 16'd768;
    localparam logic [IDX_W-1:0]  FIRST_BIN_RST = 11'd6;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 3'd0,
        KIND_SINGLE = 3'd1,
        KIND_MAJOR  = 3'd2,
        KIND_MINOR  = 3'd3,
        KIND_DIM    = 3'd4,
        KIND_AUG    = 3'd5
    } chord_kind_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [STEP_W-1:0] bin_step;
        logic [IDX_W-1:0]  first_bin;
    } cfg_regs_t;

    typedef struct packed {
        logic            hit;
        logic [PC_W-1:0] pclass;
        logic            last;
    } bin_entry_t;

    typedef struct packed {
        chord_kind_t      kind;
        logic [PC_W-1:0]  root;
        logic [PC_N-1:0]  pitch_set;
        logic [CNT_W-1:0] pitch_count;
    } chord_result_t;

    // Semitone midpoints C4..C5 folded into [2^31, 2^32)
    localparam logic [NORM_W-1:0] PC_BOUND [PC_N] = '{
        32'd2258983176, 32'd2393309306, 32'd2535622883, 32'd2686398866,
        32'd2846140455, 32'd3015380773, 32'd3194684645, 32'd3384650479,
        32'd3585912270, 32'd3799141709, 32'd4025050432, 32'd4264392385
    };

    // Triad templates rooted at C, in search order
    localparam int SHAPE_N = 4;
    localparam logic [PC_N-1:0] TRIAD_SHAPE [SHAPE_N] = '{
        12'h091, 12'h089, 12'h049, 12'h111
    };
    localparam chord_kind_t SHAPE_KIND [SHAPE_N] = '{
        KIND_MAJOR, KIND_MINOR, KIND_DIM, KIND_AUG
    };

    // Rotate a pitch-class set upward by r semitones
    function automatic logic [PC_N-1:0] rotate12(input logic [PC_N-1:0] v, input int r);
        logic [PC_N-1:0] res;
        res = (v << r) | (v >> (PC_N - r));
        return res;
    endfunction

    // Count notes and find the single note or the first matching triad
    function automatic chord_result_t classify(input logic [PC_N-1:0] mask);
        chord_result_t    res;
        logic [CNT_W-1:0] cnt;
        logic             found;
        cnt   = '0;
        found = 1'b0;
        for (int k = 0; k < PC_N; k++)
        begin
            cnt = cnt + CNT_W'(mask[k]);
        end
        res.kind        = KIND_NONE;
        res.root        = '0;
        res.pitch_set   = mask;
        res.pitch_count = cnt;
        if (cnt == CNT_W'(1))
        begin
            res.kind = KIND_SINGLE;
            for (int k = 0; k < PC_N; k++)
            begin
                if (mask[k])
                begin
                    res.root = PC_W'(k);
                end
            end
        end
        else if (cnt == CNT_W'(3))
        begin
            for (int r = 0; r < PC_N; r++)
            begin
                for (int t = 0; t < SHAPE_N; t++)
                begin
                    if (!found && rotate12(TRIAD_SHAPE[t], r) == mask)
                    begin
                        found    = 1'b1;
                        res.kind = SHAPE_KIND[t];
                        res.root = PC_W'(r);
                    end
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stbc_front.sv =====
// Front part: qualifies each bin, forms its frequency and finds its pitch class.
`default_nettype none

module stbc_front
    import stbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_regs_t         cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [MAG_W-1:0]  in_magnitude,
    input  wire logic [IDX_W-1:0]  in_bin_index,
    input  wire logic              in_last,
    output logic                   push_valid,
    output bin_entry_t             push_entry,
    input  wire logic              queue_full
);

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_hit_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic                s1_last_reg;
    logic                s2_valid_reg, s2_valid_next;
    logic                s2_hit_reg;
    logic [NORM_W-1:0]   s2_norm_reg;
    logic                s2_last_reg;
    logic                s1_ready;
    logic                s2_ready;
    logic                hit;
    logic [PROD_W-1:0]   prod;
    logic [SHIFT_W-1:0]  msb;
    logic [SHIFT_W-1:0]  shift;
    logic [NORM_W-1:0]   norm;
    logic [PC_W:0]       bound_cnt;

    // Pipeline handshake: a stage moves when the next one has room
    assign s2_ready = !s2_valid_reg || !queue_full;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: qualify the bin and form the frequency in Q8 hertz
    assign hit  = (in_bin_index >= cfg.first_bin) &&
                  (in_magnitude >= {cfg.threshold, 8'h00});
    assign prod = PROD_W'(in_bin_index) * PROD_W'(cfg.bin_step);

    // Stage 2: fold the frequency into one octave by a leading-one shift
    always_comb
    begin
        msb = '0;
        for (int k = 0; k < PROD_W; k++)
        begin
            if (s1_prod_reg[k])
            begin
                msb = SHIFT_W'(k);
            end
        end
        shift = SHIFT_W'(NORM_W - 1) - msb;
        norm  = NORM_W'(s1_prod_reg) << shift;
    end

    // Pitch class: number of semitone boundaries reached, twelve wraps to C
    always_comb
    begin
        bound_cnt = '0;
        for (int k = 0; k < PC_N; k++)
        begin
            if (s2_norm_reg >= PC_BOUND[k])
            begin
                bound_cnt = bound_cnt + (PC_W+1)'(1);
            end
        end
        push_entry.hit    = s2_hit_reg;
        push_entry.last   = s2_last_reg;
        push_entry.pclass = (bound_cnt == (PC_W+1)'(PC_N)) ? '0 : bound_cnt[PC_W-1:0];
    end

    assign push_valid = s2_valid_reg;

    // Stage valid bits
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = in_valid;
        end
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_hit_reg  <= hit;
            s1_prod_reg <= prod;
            s1_last_reg <= in_last;
        end
        if (s2_ready)
        begin
            s2_hit_reg  <= s1_hit_reg;
            s2_norm_reg <= norm;
            s2_last_reg <= s1_last_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stbc_queue.sv =====
// Short queue of classified bins between the front and back parts.
`default_nettype none

module stbc_queue
    import stbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    input  wire bin_entry_t  push_entry,
    output logic             full,
    output logic             pop_valid,
    output bin_entry_t       pop_entry,
    input  wire logic        pop
);

    bin_entry_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]       count_reg, count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + QUEUE_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QUEUE_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stbc_back.sv =====
// Back part: collects pitch classes per frame and classifies the chord on the last bin.
`default_nettype none

module stbc_back
    import stbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        entry_valid,
    input  wire bin_entry_t  entry,
    output logic             entry_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output chord_result_t    out_result
);

    logic [PC_N-1:0]  mask_reg, mask_next;
    logic             out_valid_reg, out_valid_next;
    chord_result_t    out_result_reg;
    logic             out_free;
    logic [PC_N-1:0]  merged;
    logic             load_result;

    // The output register is free when empty or being taken this cycle
    assign out_free    = !out_valid_reg || out_ready;
    assign entry_pop   = entry_valid && (!entry.last || out_free);
    assign load_result = entry_pop && entry.last;
    assign merged      = mask_reg | (entry.hit ? (PC_N'(1) << entry.pclass) : '0);

    // Mask collection and output register control
    always_comb
    begin
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (entry_pop)
        begin
            mask_next = entry.last ? '0 : merged;
        end
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_result_reg <= classify(merged);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

`default_nettype wire

// ===== rtl/spectrum_bins_to_triad_chord.sv =====
// Top level: configuration registers and the front, queue and back parts.
//
//  channel   direction  transfers            payload
//  s_*       in         one spectrum bin     tdata: magnitude, bin_index; tlast: last
//  m_*       out        one chord per frame  tdata: chord_kind, root, pitch_set, pitch_count
//  cfg_*     in         one register write   cfg_index, cfg_data
//
// One bin is taken every cycle while the result side keeps up.
// A frame result is offered on m_* once its last bin has passed the two front stages and
// the queue, and the queue head has been merged and classified into the output register.
// Reset clears the pitch mask, the pipeline and the queue and loads the configuration reset values; no sweep follows.
// A stalled result holds the back part only on the next last bin; the four-entry
// queue then fills and the input side stalls.
`default_nettype none

module spectrum_bins_to_triad_chord
    import stbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // tdata fields from bit 0: magnitude[23:0], bin_index[34:24], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata fields from bit 0: chord_kind[2:0], root[6:3], pitch_set[18:7],
    // pitch_count[22:19], zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [THR_W-1:0]      cfg_data
);

    cfg_regs_t      cfg_reg, cfg_next;
    logic           push_valid;
    bin_entry_t     push_entry;
    logic           queue_full;
    logic           pop_valid;
    bin_entry_t     pop_entry;
    logic           pop;
    chord_result_t  result;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_next.threshold = cfg_data;
                CFG_BIN_STEP:  cfg_next.bin_step  = cfg_data;
                CFG_FIRST_BIN: cfg_next.first_bin = cfg_data[IDX_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= THRESHOLD_RST;
            cfg_reg.bin_step  <= BIN_STEP_RST;
            cfg_reg.first_bin <= FIRST_BIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    stbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_magnitude (s_tdata[MAG_W-1:0]),
        .in_bin_index (s_tdata[MAG_W+IDX_W-1:MAG_W]),
        .in_last      (s_tlast),
        .push_valid   (push_valid),
        .push_entry   (push_entry),
        .queue_full   (queue_full)
    );

    stbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    stbc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (pop_valid),
        .entry       (pop_entry),
        .entry_pop   (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    // Result packing, first field in the lowest bits
    assign m_tdata = {1'b0, result.pitch_count, result.pitch_set, result.root, result.kind};

endmodule

`default_nettype wire

// ===== rtl/stbc_checker.sv =====
// Port-level checks on the chord results, bound to the top level.
`default_nettype none

module stbc_checker
    import stbc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready
);

    logic [KIND_W-1:0] kind;
    logic [PC_W-1:0]   root;
    logic [CNT_W-1:0]  cnt;

    assign kind = m_tdata[KIND_W-1:0];
    assign root = m_tdata[KIND_W+PC_W-1:KIND_W];
    assign cnt  = m_tdata[OUT_DATA_W-2:OUT_DATA_W-1-CNT_W];

    // A stalled result stays offered and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // No chord means root C
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind == KIND_NONE |-> root == '0)
        else $error("root set without a chord");

    // A single note comes from exactly one pitch class
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind == KIND_SINGLE |-> cnt == CNT_W'(1))
        else $error("single note with wrong note count");

    // A triad comes from exactly three pitch classes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (kind == KIND_MAJOR || kind == KIND_MINOR ||
                     kind == KIND_DIM || kind == KIND_AUG) |-> cnt == CNT_W'(3))
        else $error("triad with wrong note count");

    // The note count matches the pitch set and the root is a pitch class
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt == CNT_W'($countones(m_tdata[KIND_W+PC_W+PC_N-1:KIND_W+PC_W]))
                     && root < PC_W'(PC_N))
        else $error("note count or root out of line with pitch set");

endmodule

bind spectrum_bins_to_triad_chord stbc_checker u_stbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
